// ----- rtl/core/estc_pkg.sv -----
// Shared types, command codes and calendar constants for the epoch-to-calendar converter.
package estc_pkg;

	// Datapath operation codes
	typedef logic [3:0] op_t;
	localparam op_t OP_IDLE  = 4'd0;
	localparam op_t OP_LOAD  = 4'd1;
	localparam op_t OP_DIV   = 4'd2;
	localparam op_t OP_SEC   = 4'd3;
	localparam op_t OP_MIN   = 4'd4;
	localparam op_t OP_HOUR  = 4'd5;
	localparam op_t OP_YEAR4 = 4'd6;
	localparam op_t OP_YEAR  = 4'd7;
	localparam op_t OP_MONTH = 4'd8;
	localparam op_t OP_PUB   = 4'd9;

	// Command from controller to datapath
	typedef struct packed {
		op_t  op;
		logic dsel;  // divisor select: 0 = 60, 1 = 24
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic blk_ge;  // day count covers a whole four-year block
		logic yr_ge;   // day count covers the current year
		logic mon_go;  // day count covers the current month and month is not December
	} status_t;

	localparam logic [31:0] EPOCH_OFFSET = 32'd946684800;
	localparam logic [6:0]  DIV_MIN      = 7'd60;
	localparam logic [6:0]  DIV_HOUR     = 7'd24;
	localparam logic [8:0]  DAYS_YEAR    = 9'd365;
	localparam logic [15:0] DAYS_BLOCK   = 16'd1461;
	localparam logic [3:0]  MONTHS       = 4'd12;

	// Reciprocals for any 32-bit x: x / 60 = (x * RECIP_MIN) >> 37,
	// x / 24 = (x * RECIP_HOUR) >> 36
	localparam logic [31:0] RECIP_MIN  = 32'h8888_8889;
	localparam logic [31:0] RECIP_HOUR = 32'hAAAA_AAAB;

	// Days in a month, February extended in leap years
	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			4'd2:    len = leap ? 5'd29 : 5'd28;
			4'd4:    len = 5'd30;
			4'd6:    len = 5'd30;
			4'd9:    len = 5'd30;
			4'd11:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ----- rtl/core/epoch_seconds_to_calendar.sv -----
// Top level of the epoch-seconds to calendar-date converter.
// Converts a 32-bit count of seconds since 1970 into years since 2000, month, day, hour,
// minute and second (every fourth year leap, no century rule; times before 2000 wrap).
// One request at a time: the next request is accepted the cycle after the result is
// registered. The work is three constant divisions (a reciprocal multiply and a
// remainder step each), one four-year subtraction per cycle (up to 34), one year step
// per cycle (up to 3) and one month step per cycle (up to 11), then the publish step.
// A finished result waits in an output register, so a stalled consumer holds back only
// the final publish.
module epoch_seconds_to_calendar import estc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  year_offset,
	output logic [3:0]  month_num,
	output logic [4:0]  day_of_month,
	output logic [4:0]  hour_num,
	output logic [5:0]  minute_num,
	output logic [5:0]  second_num
);

	cmd_t    cmd;
	status_t st;

	// Sequence the conversion
	estc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// Do the arithmetic and hold the result
	estc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.epoch_seconds (epoch_seconds),
		.st            (st),
		.year_offset   (year_offset),
		.month_num     (month_num),
		.day_of_month  (day_of_month),
		.hour_num      (hour_num),
		.minute_num    (minute_num),
		.second_num    (second_num)
	);

endmodule

// ----- rtl/core/estc_dp.sv -----
// Datapath: reciprocal-multiply constant divider, year and month subtractors, result registers.
module estc_dp import estc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [31:0] epoch_seconds,
	output status_t     st,
	output logic [6:0]  year_offset,
	output logic [3:0]  month_num,
	output logic [4:0]  day_of_month,
	output logic [4:0]  hour_num,
	output logic [5:0]  minute_num,
	output logic [5:0]  second_num
);

	logic [31:0] work_q;
	logic [31:0] quo_q;
	logic [15:0] days_q;
	logic [7:0]  year_q;
	logic [3:0]  month_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;

	logic [6:0]  dv;
	logic [31:0] recip;
	logic [63:0] prod;
	logic [31:0] quo;
	logic [31:0] rem;
	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  mlen;

	// Quotient by 60 or 24 through a reciprocal multiply
	assign dv    = cmd.dsel ? DIV_HOUR : DIV_MIN;
	assign recip = cmd.dsel ? RECIP_HOUR : RECIP_MIN;
	assign prod  = {32'd0, work_q} * {32'd0, recip};
	assign quo   = cmd.dsel ? {4'd0, prod[63:36]} : {5'd0, prod[63:37]};

	// Remainder from the registered quotient
	assign rem = work_q - quo_q * {25'd0, dv};

	// Year and month lengths
	assign leap = (year_q[1:0] == 2'd0);
	assign ylen = DAYS_YEAR + {8'd0, leap};
	assign mlen = month_len(month_q, leap);

	assign st.blk_ge = (days_q >= DAYS_BLOCK);
	assign st.yr_ge  = (days_q >= {7'd0, ylen});
	assign st.mon_go = (days_q >= {11'd0, mlen}) && (month_q < MONTHS);

	// Execute the controller's command
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				work_q <= epoch_seconds - EPOCH_OFFSET;
			end
			OP_DIV: begin
				quo_q <= quo;
			end
			OP_SEC: begin
				sec_q  <= rem[5:0];
				work_q <= quo_q;
			end
			OP_MIN: begin
				min_q  <= rem[5:0];
				work_q <= quo_q;
			end
			OP_HOUR: begin
				hour_q  <= rem[4:0];
				days_q  <= quo_q[15:0];
				year_q  <= 8'd0;
				month_q <= 4'd1;
			end
			OP_YEAR4: begin
				days_q <= days_q - DAYS_BLOCK;
				year_q <= year_q + 8'd4;
			end
			OP_YEAR: begin
				days_q <= days_q - {7'd0, ylen};
				year_q <= year_q + 8'd1;
			end
			OP_MONTH: begin
				days_q  <= days_q - {11'd0, mlen};
				month_q <= month_q + 4'd1;
			end
			OP_PUB: begin
				year_offset  <= year_q[6:0];
				month_num    <= month_q;
				day_of_month <= days_q[4:0] + 5'd1;
				hour_num     <= hour_q;
				minute_num   <= min_q;
				second_num   <= sec_q;
			end
			default: begin
			end
		endcase
	end

	// Remainder stays below the divisor whenever it is taken
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.op == OP_SEC) || (cmd.op == OP_MIN) || (cmd.op == OP_HOUR))
		|-> (rem < {25'd0, dv}))
		else $error("divider remainder out of range");

	// Whole-block subtraction only when the day count covers the block
	a_blk_sub: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_YEAR4) |-> st.blk_ge)
		else $error("four-year subtraction without enough days");

	// Month advance never passes December
	a_month_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_MONTH) |=> (month_q <= MONTHS))
		else $error("month advanced past December");

endmodule

// ----- rtl/core/estc_ctrl.sv -----
// Controller: sequences division, year and month passes and the output handshake.
module estc_ctrl import estc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t st,
	output cmd_t    cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_D1   = 4'd1;
	localparam logic [3:0] S_A1   = 4'd2;
	localparam logic [3:0] S_D2   = 4'd3;
	localparam logic [3:0] S_A2   = 4'd4;
	localparam logic [3:0] S_D3   = 4'd5;
	localparam logic [3:0] S_A3   = 4'd6;
	localparam logic [3:0] S_Y4   = 4'd7;
	localparam logic [3:0] S_Y1   = 4'd8;
	localparam logic [3:0] S_MO   = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       pub;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign pub       = (cmd.op == OP_PUB);

	// Next state and command
	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_IDLE;
		cmd.dsel = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_D1;
				end
			end
			S_D1: begin
				cmd.op  = OP_DIV;
				state_d = S_A1;
			end
			S_A1: begin
				cmd.op  = OP_SEC;
				state_d = S_D2;
			end
			S_D2: begin
				cmd.op  = OP_DIV;
				state_d = S_A2;
			end
			S_A2: begin
				cmd.op  = OP_MIN;
				state_d = S_D3;
			end
			S_D3: begin
				cmd.op   = OP_DIV;
				cmd.dsel = 1'b1;
				state_d  = S_A3;
			end
			S_A3: begin
				cmd.op   = OP_HOUR;
				cmd.dsel = 1'b1;
				state_d  = S_Y4;
			end
			S_Y4: begin
				if (st.blk_ge) cmd.op = OP_YEAR4;
				else state_d = S_Y1;
			end
			S_Y1: begin
				if (st.yr_ge) cmd.op = OP_YEAR;
				else state_d = S_MO;
			end
			S_MO: begin
				if (st.mon_go) cmd.op = OP_MONTH;
				else state_d = S_DONE;
			end
			S_DONE: begin
				// hold the finished request until the output register frees up
				if (!out_valid_q || !out_stall) begin
					cmd.op  = OP_PUB;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= pub | (out_valid_q & out_stall);
		end
	end

	// A new result appears only after the finish state
	a_pub_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result published outside finish state");

	// First quotient is always followed by its remainder step
	a_div1_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_D1) |=> (state_q == S_A1))
		else $error("seconds division did not finish");

	// Month pass ends in the finish state
	a_mon_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MO && !st.mon_go) |=> (state_q == S_DONE))
		else $error("month pass did not finish");

endmodule
